// ===== sv/dfq_pkg.sv =====
// Package for the deduplicating FIFO queue.
// Holds the item layout, status codes, controller states and the command/status structs.
// Depends on nothing.
package dfq_pkg;

    localparam int WIDTH       = 32;
    localparam int ST_W        = 2;
    localparam int OCC_W       = 5;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;
    localparam int DATA_LSB    = ST_W;
    localparam int OCC_LSB     = ST_W + WIDTH;
    localparam int M_USED_W    = ST_W + WIDTH + OCC_W;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_CHECK,
        S_DEQ,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic    load_item;
        logic    scan_start;
        logic    rd_issue;
        logic    scan_adv;
        logic    commit_enq;
        logic    commit_deq;
        logic    load_out;
        status_t out_status;
    } cmd_t;

    typedef struct packed {
        logic is_deq;
        logic full;
        logic empty;
        logic scan_end;
        logic match;
        logic out_free;
    } stat_t;

endpackage

// ===== sv/dfq_ctrl.sv =====
// Controller state machine of the deduplicating FIFO queue.
// Sequences classify, serial duplicate scan, dequeue read and result load.
// Depends on dfq_pkg.
module dfq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  dfq_pkg::stat_t stat,
    output dfq_pkg::cmd_t  cmd
);

    dfq_pkg::state_t  state_reg;
    dfq_pkg::state_t  state_next;
    dfq_pkg::status_t st_reg;
    dfq_pkg::status_t st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dfq_pkg::S_IDLE;
            st_reg    <= dfq_pkg::ST_DONE;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        s_axis_tready  = 1'b0;
        cmd.load_item  = 1'b0;
        cmd.scan_start = 1'b0;
        cmd.rd_issue   = 1'b0;
        cmd.scan_adv   = 1'b0;
        cmd.commit_enq = 1'b0;
        cmd.commit_deq = 1'b0;
        cmd.load_out   = 1'b0;
        cmd.out_status = st_reg;
        unique case (state_reg)
            dfq_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load_item  = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = dfq_pkg::S_CLASSIFY;
                end
            end
            dfq_pkg::S_CLASSIFY:
            begin
                if (stat.is_deq)
                begin
                    if (stat.empty)
                    begin
                        st_next    = dfq_pkg::ST_EMPTY;
                        state_next = dfq_pkg::S_RESULT;
                    end
                    else
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next   = dfq_pkg::S_DEQ;
                    end
                end
                else if (stat.full)
                begin
                    st_next    = dfq_pkg::ST_FULL;
                    state_next = dfq_pkg::S_RESULT;
                end
                else if (stat.scan_end)
                begin
                    cmd.commit_enq = 1'b1;
                    st_next        = dfq_pkg::ST_DONE;
                    state_next     = dfq_pkg::S_RESULT;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    cmd.scan_adv = 1'b1;
                    state_next   = dfq_pkg::S_CHECK;
                end
            end
            dfq_pkg::S_CHECK:
            begin
                if (stat.match)
                begin
                    st_next    = dfq_pkg::ST_DUP;
                    state_next = dfq_pkg::S_RESULT;
                end
                else if (stat.scan_end)
                begin
                    cmd.commit_enq = 1'b1;
                    st_next        = dfq_pkg::ST_DONE;
                    state_next     = dfq_pkg::S_RESULT;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    cmd.scan_adv = 1'b1;
                end
            end
            dfq_pkg::S_DEQ:
            begin
                cmd.commit_deq = 1'b1;
                st_next        = dfq_pkg::ST_DONE;
                state_next     = dfq_pkg::S_RESULT;
            end
            dfq_pkg::S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = dfq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dfq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/dfq_datapath.sv =====
// Datapath of the deduplicating FIFO queue: entry memory, head and count,
// scan pointer, compare, and the output register. Depends on dfq_pkg.
module dfq_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [dfq_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [dfq_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  dfq_pkg::cmd_t                     cmd,
    output dfq_pkg::stat_t                    stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [dfq_pkg::WIDTH-1:0]     mem [DEPTH];
    logic [dfq_pkg::WIDTH-1:0]     item_reg;
    dfq_pkg::kind_t                kind_reg;
    logic [dfq_pkg::WIDTH-1:0]     rd_data_reg;
    logic [AW-1:0]                 head_reg;
    logic [CW-1:0]                 count_reg;
    logic [AW-1:0]                 ptr_reg;
    logic [CW-1:0]                 idx_reg;
    logic                          out_valid_reg;
    logic [dfq_pkg::M_TDATA_W-1:0] out_tdata_reg;

    logic [AW:0]                   tail_sum;
    logic [AW:0]                   tail_wrap;
    logic [AW-1:0]                 tail_addr;
    logic [AW-1:0]                 head_inc;
    logic [AW-1:0]                 ptr_inc;
    logic [31:0]                   occ_wide;
    logic [dfq_pkg::WIDTH-1:0]     res_data;
    logic [dfq_pkg::M_TDATA_W-1:0] out_tdata_next;

    assign tail_sum  = {1'b0, head_reg} + (AW+1)'(count_reg);
    assign tail_wrap = (tail_sum >= (AW+1)'(DEPTH)) ? tail_sum - (AW+1)'(DEPTH) : tail_sum;
    assign tail_addr = tail_wrap[AW-1:0];
    assign head_inc  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign ptr_inc   = (ptr_reg == AW'(DEPTH - 1)) ? '0 : ptr_reg + 1'b1;

    assign stat.is_deq   = (kind_reg == dfq_pkg::KIND_DEQ);
    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.empty    = (count_reg == '0);
    assign stat.scan_end = (idx_reg == count_reg);
    assign stat.match    = (rd_data_reg == item_reg);
    assign stat.out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (cmd.commit_enq)
        begin
            mem[tail_addr] <= item_reg;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[ptr_reg];
        end
        if (cmd.load_item)
        begin
            item_reg <= s_axis_tdata[dfq_pkg::WIDTH-1:0];
            kind_reg <= dfq_pkg::kind_t'(s_axis_tuser);
        end
        if (cmd.load_out)
        begin
            out_tdata_reg <= out_tdata_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                ptr_reg <= head_reg;
                idx_reg <= '0;
            end
            else if (cmd.scan_adv)
            begin
                ptr_reg <= ptr_inc;
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.commit_enq)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.commit_deq)
            begin
                count_reg <= count_reg - 1'b1;
                head_reg  <= head_inc;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        occ_wide = 32'(count_reg);
        res_data = ((cmd.out_status == dfq_pkg::ST_DONE) && stat.is_deq) ? rd_data_reg : '0;
        out_tdata_next = '0;
        out_tdata_next[dfq_pkg::ST_W-1:0] = cmd.out_status;
        out_tdata_next[dfq_pkg::DATA_LSB +: dfq_pkg::WIDTH] = res_data;
        out_tdata_next[dfq_pkg::OCC_LSB +: dfq_pkg::OCC_W] = occ_wide[dfq_pkg::OCC_W-1:0];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tdata_reg;

endmodule

// ===== sv/dedup_fifo_queue.sv =====
// Top level of the deduplicating FIFO queue: controller plus datapath.
// Depends on dfq_pkg, dfq_ctrl and dfq_datapath.
//
// One item at a time. An enqueue compares the stored entries, at most the occupancy,
// until a match or the end, since the duplicate search reads the entry memory one
// entry per cycle through its single read port. A full enqueue or an empty dequeue
// goes from classify straight to result, a dequeue through a read state between.
// The result sits in an output register, so the next item is taken while it waits;
// only a second result stalls. No clearing pass after reset.
module dedup_fifo_queue #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [dfq_pkg::S_TDATA_W-1:0] s_axis_tdata,   // item_value
    input  logic                          s_axis_tuser,   // kind
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [dfq_pkg::M_TDATA_W-1:0] m_axis_tdata    // status, data_out, occupancy, pad
);

    dfq_pkg::cmd_t  cmd;
    dfq_pkg::stat_t stat;

    dfq_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    dfq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

// ===== sv/dfq_checker.sv =====
// Port-level checker for the deduplicating FIFO queue, bound to the top level.
// Depends on dfq_pkg and dedup_fifo_queue.
module dfq_checker #(
    parameter int DEPTH = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [dfq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                          s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [dfq_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    logic [dfq_pkg::ST_W-1:0]  st;
    logic [dfq_pkg::WIDTH-1:0] dout;
    logic [dfq_pkg::OCC_W-1:0] occ;
    logic                      in_busy;

    assign st      = m_axis_tdata[dfq_pkg::ST_W-1:0];
    assign dout    = m_axis_tdata[dfq_pkg::DATA_LSB +: dfq_pkg::WIDTH];
    assign occ     = m_axis_tdata[dfq_pkg::OCC_LSB +: dfq_pkg::OCC_W];
    assign in_busy = s_axis_tvalid && s_axis_tready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (st == dfq_pkg::ST_EMPTY) |-> (dout == '0) && (occ == '0))
        else $error("empty result with nonzero data or occupancy");

    a_nodata: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((st == dfq_pkg::ST_DUP) || (st == dfq_pkg::ST_FULL)) |-> dout == '0)
        else $error("rejected enqueue returned data");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (st == dfq_pkg::ST_FULL) |-> occ == dfq_pkg::OCC_W'(DEPTH))
        else $error("full result without full occupancy");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_busy |=> !s_axis_tready)
        else $error("item taken while previous one in work");

endmodule

bind dedup_fifo_queue dfq_checker #(
    .DEPTH (DEPTH)
) u_dfq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
